// ----- design/assert_macros.svh -----
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is asserted
`define DCV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition holds whenever the result strobe is high
`define DCV_ASSERT_ON_DONE(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) done |-> (cond)) else $error(msg);

`endif

// ----- design/dcv_pkg.sv -----
// Shared types and constants for the draw command validator
package dcv_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned PROD_W    = 26;
    localparam int unsigned COORD_W   = 12;

    localparam logic [DATA_W-1:0] TRI_MAX_DIM = 32'd4095;

    typedef enum logic [2:0] {
        ST_VALID       = 3'd0,
        ST_BAD_SURFACE = 3'd1,
        ST_OVERFLOW    = 3'd2,
        ST_TOO_SMALL   = 3'd3,
        ST_RECT_OUT    = 3'd4,
        ST_TRI_OUT     = 3'd5,
        ST_DEGENERATE  = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        CMD_SURFACE = 2'd0,
        CMD_RECT    = 2'd1,
        CMD_TRI     = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SURFACE_WIDTH  = 2'd0,
        CFG_SURFACE_HEIGHT = 2'd1,
        CFG_ROW_PITCH      = 2'd2,
        CFG_BUFFER_BYTES   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic                      rect_out;
        logic                      tri_out;
        logic signed [PROD_W-1:0]  area_lhs;
        logic signed [PROD_W-1:0]  area_rhs;
    } geom_flags_t;

endpackage

// ----- design/dcv_geom_check.sv -----
// Rectangle and triangle geometry checks against the configured surface
module dcv_geom_check
    import dcv_pkg::*;
(
    input  logic [DATA_W-1:0]        surface_width,
    input  logic [DATA_W-1:0]        surface_height,
    input  logic [DATA_W-1:0]        rect_x,
    input  logic [DATA_W-1:0]        rect_y,
    input  logic [DATA_W-1:0]        rect_width,
    input  logic [DATA_W-1:0]        rect_height,
    input  logic signed [DATA_W-1:0] vertex_a_x,
    input  logic signed [DATA_W-1:0] vertex_a_y,
    input  logic signed [DATA_W-1:0] vertex_b_x,
    input  logic signed [DATA_W-1:0] vertex_b_y,
    input  logic signed [DATA_W-1:0] vertex_c_x,
    input  logic signed [DATA_W-1:0] vertex_c_y,
    output geom_flags_t              flags
);

    function automatic logic in_surface(
        input logic signed [DATA_W-1:0] x,
        input logic signed [DATA_W-1:0] y,
        input logic [DATA_W-1:0]        w,
        input logic [DATA_W-1:0]        h
    );
        return !x[DATA_W-1] && !y[DATA_W-1] &&
               (unsigned'(x) < w) && (unsigned'(y) < h);
    endfunction

    function automatic logic signed [COORD_W:0] coord_diff(
        input logic signed [DATA_W-1:0] p,
        input logic signed [DATA_W-1:0] q
    );
        return signed'({1'b0, p[COORD_W-1:0]}) - signed'({1'b0, q[COORD_W-1:0]});
    endfunction

    logic                     dim_over;
    logic signed [COORD_W:0]  d_bax;
    logic signed [COORD_W:0]  d_cay;
    logic signed [COORD_W:0]  d_bay;
    logic signed [COORD_W:0]  d_cax;

    assign dim_over = (surface_width > TRI_MAX_DIM) || (surface_height > TRI_MAX_DIM);

    assign d_bax = coord_diff(vertex_b_x, vertex_a_x);
    assign d_cay = coord_diff(vertex_c_y, vertex_a_y);
    assign d_bay = coord_diff(vertex_b_y, vertex_a_y);
    assign d_cax = coord_diff(vertex_c_x, vertex_a_x);

    always_comb
    begin
        flags.rect_out = (rect_width == '0) || (rect_height == '0) ||
                         (rect_x >= surface_width) || (rect_y >= surface_height) ||
                         (rect_width > (surface_width - rect_x)) ||
                         (rect_height > (surface_height - rect_y));
        flags.tri_out  = dim_over ||
                         !in_surface(vertex_a_x, vertex_a_y, surface_width, surface_height) ||
                         !in_surface(vertex_b_x, vertex_b_y, surface_width, surface_height) ||
                         !in_surface(vertex_c_x, vertex_c_y, surface_width, surface_height);
        flags.area_lhs = PROD_W'(d_bax) * PROD_W'(d_cay);
        flags.area_rhs = PROD_W'(d_bay) * PROD_W'(d_cax);
    end

endmodule

// ----- design/draw_command_validator.sv -----
// Draw command validator top level: configuration, pipeline and status decision
//
// Takes one command per clock: busy never rises, so start may be high in every
// cycle. Each command gives one result on status, accepted and byte_count,
// shown for exactly one cycle with done high, after passing the input register,
// a stage holding the 32x32 surface byte-count product and the two triangle
// area products, then the result register. Results leave in command order and
// cannot be held off by the receiver. The configuration channel is always
// ready; write it only with no command in flight.
module draw_command_validator
    import dcv_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               command,
    input  logic [DATA_W-1:0]        rect_x,
    input  logic [DATA_W-1:0]        rect_y,
    input  logic [DATA_W-1:0]        rect_width,
    input  logic [DATA_W-1:0]        rect_height,
    input  logic signed [DATA_W-1:0] vertex_a_x,
    input  logic signed [DATA_W-1:0] vertex_a_y,
    input  logic signed [DATA_W-1:0] vertex_b_x,
    input  logic signed [DATA_W-1:0] vertex_b_y,
    input  logic signed [DATA_W-1:0] vertex_c_x,
    input  logic signed [DATA_W-1:0] vertex_c_y,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    output logic                     done,
    output logic [2:0]               status,
    output logic                     accepted,
    output logic [DATA_W-1:0]        byte_count
);

    logic [DATA_W-1:0] surface_width_reg;
    logic [DATA_W-1:0] surface_height_reg;
    logic [DATA_W-1:0] row_pitch_reg;
    logic [DATA_W-1:0] buffer_bytes_reg;

    logic                     s0_valid_reg;
    cmd_t                     s0_cmd_reg;
    logic [DATA_W-1:0]        s0_rect_x_reg;
    logic [DATA_W-1:0]        s0_rect_y_reg;
    logic [DATA_W-1:0]        s0_rect_w_reg;
    logic [DATA_W-1:0]        s0_rect_h_reg;
    logic signed [DATA_W-1:0] s0_ax_reg;
    logic signed [DATA_W-1:0] s0_ay_reg;
    logic signed [DATA_W-1:0] s0_bx_reg;
    logic signed [DATA_W-1:0] s0_by_reg;
    logic signed [DATA_W-1:0] s0_cx_reg;
    logic signed [DATA_W-1:0] s0_cy_reg;

    logic                     s1_valid_reg;
    cmd_t                     s1_cmd_reg;
    logic [2*DATA_W-1:0]      s1_bytes_reg;
    logic                     s1_bad_reg;
    logic                     s1_pitch_ovf_reg;
    geom_flags_t              s1_flags_reg;

    logic [DATA_W-1:0]        pitch_bytes;
    logic [2*DATA_W-1:0]      bytes_next;
    logic                     bad_next;
    geom_flags_t              flags_next;

    status_t                  surf_status;
    status_t                  status_next;

    logic                     done_reg;
    status_t                  status_reg;
    logic                     accepted_reg;
    logic [DATA_W-1:0]        byte_count_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            surface_width_reg  <= '0;
            surface_height_reg <= '0;
            row_pitch_reg      <= '0;
            buffer_bytes_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SURFACE_WIDTH:  surface_width_reg  <= cfg_data;
                CFG_SURFACE_HEIGHT: surface_height_reg <= cfg_data;
                CFG_ROW_PITCH:      row_pitch_reg      <= cfg_data;
                CFG_BUFFER_BYTES:   buffer_bytes_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else
            s0_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            s0_cmd_reg    <= cmd_t'(command);
            s0_rect_x_reg <= rect_x;
            s0_rect_y_reg <= rect_y;
            s0_rect_w_reg <= rect_width;
            s0_rect_h_reg <= rect_height;
            s0_ax_reg     <= vertex_a_x;
            s0_ay_reg     <= vertex_a_y;
            s0_bx_reg     <= vertex_b_x;
            s0_by_reg     <= vertex_b_y;
            s0_cx_reg     <= vertex_c_x;
            s0_cy_reg     <= vertex_c_y;
        end
    end

    assign pitch_bytes = {row_pitch_reg[DATA_W-3:0], 2'b00};
    assign bytes_next  = {{DATA_W{1'b0}}, pitch_bytes} * {{DATA_W{1'b0}}, surface_height_reg};
    assign bad_next    = (surface_width_reg == '0) || (surface_height_reg == '0) ||
                         (row_pitch_reg < surface_width_reg) || (buffer_bytes_reg == '0);

    dcv_geom_check u_geom (
        .surface_width  (surface_width_reg),
        .surface_height (surface_height_reg),
        .rect_x         (s0_rect_x_reg),
        .rect_y         (s0_rect_y_reg),
        .rect_width     (s0_rect_w_reg),
        .rect_height    (s0_rect_h_reg),
        .vertex_a_x     (s0_ax_reg),
        .vertex_a_y     (s0_ay_reg),
        .vertex_b_x     (s0_bx_reg),
        .vertex_b_y     (s0_by_reg),
        .vertex_c_x     (s0_cx_reg),
        .vertex_c_y     (s0_cy_reg),
        .flags          (flags_next)
    );

    // product stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s0_valid_reg)
        begin
            s1_cmd_reg       <= s0_cmd_reg;
            s1_bytes_reg     <= bytes_next;
            s1_bad_reg       <= bad_next;
            s1_pitch_ovf_reg <= |row_pitch_reg[DATA_W-1:DATA_W-2];
            s1_flags_reg     <= flags_next;
        end
    end

    always_comb
    begin
        if (s1_bad_reg)
            surf_status = ST_BAD_SURFACE;
        else if (s1_pitch_ovf_reg || (s1_bytes_reg[2*DATA_W-1:DATA_W] != '0))
            surf_status = ST_OVERFLOW;
        else if (s1_bytes_reg[DATA_W-1:0] > buffer_bytes_reg)
            surf_status = ST_TOO_SMALL;
        else
            surf_status = ST_VALID;

        status_next = surf_status;
        if (surf_status == ST_VALID)
        begin
            case (s1_cmd_reg)
                CMD_RECT:
                begin
                    if (s1_flags_reg.rect_out)
                        status_next = ST_RECT_OUT;
                end
                CMD_TRI:
                begin
                    if (s1_flags_reg.tri_out)
                        status_next = ST_TRI_OUT;
                    else if (s1_flags_reg.area_lhs == s1_flags_reg.area_rhs)
                        status_next = ST_DEGENERATE;
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            status_reg     <= status_next;
            accepted_reg   <= (status_next == ST_VALID);
            byte_count_reg <= (surf_status == ST_VALID) ? s1_bytes_reg[DATA_W-1:0] : '0;
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign accepted   = accepted_reg;
    assign byte_count = byte_count_reg;

endmodule

// ----- design/dcv_checker.sv -----
// Port-level checker for the draw command validator, bound to the top level
`include "assert_macros.svh"

module dcv_checker
    import dcv_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic [2:0]        status,
    input logic              accepted,
    input logic [DATA_W-1:0] byte_count
);

    `DCV_ASSERT(a_result_follows, start && !busy |-> ##3 done, "command transfer gave no result")
    `DCV_ASSERT(a_no_stray_result, done |-> $past(start && !busy, 3), "result without a command")
    `DCV_ASSERT_ON_DONE(a_accepted_match, accepted == (status == ST_VALID), "accepted disagrees with status")
    `DCV_ASSERT_ON_DONE(a_bytes_on_fail, !(status == ST_BAD_SURFACE || status == ST_OVERFLOW || status == ST_TOO_SMALL) || byte_count == '0, "byte count on failed surface")
    `DCV_ASSERT_ON_DONE(a_status_code, status != 3'd7, "undefined status code")

endmodule

bind draw_command_validator dcv_checker u_dcv_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .accepted   (accepted),
    .byte_count (byte_count)
);

// ----- bench/draw_command_validator_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the draw command validator: directed corners, then random traffic
module draw_command_validator_tb;
    import dcv_pkg::*;

    localparam int          PIPE_LATENCY = 3;
    localparam logic [63:0] U32_MAX      = 64'hFFFF_FFFF;
    localparam logic [1:0]  CMD_SPARE    = 2'd3;

    typedef struct {
        logic [1:0]               cmd;
        logic [DATA_W-1:0]        rx, ry, rw, rh;
        logic signed [DATA_W-1:0] ax, ay, bx, by, cx, cy;
    } draw_cmd_t;

    typedef struct {
        status_t           st;
        logic              acc;
        logic [DATA_W-1:0] bytes;
    } verdict_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [1:0]               command;
    logic [DATA_W-1:0]        rect_x;
    logic [DATA_W-1:0]        rect_y;
    logic [DATA_W-1:0]        rect_width;
    logic [DATA_W-1:0]        rect_height;
    logic signed [DATA_W-1:0] vertex_a_x;
    logic signed [DATA_W-1:0] vertex_a_y;
    logic signed [DATA_W-1:0] vertex_b_x;
    logic signed [DATA_W-1:0] vertex_b_y;
    logic signed [DATA_W-1:0] vertex_c_x;
    logic signed [DATA_W-1:0] vertex_c_y;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DATA_W-1:0]        cfg_data;
    logic                     done;
    logic [2:0]               status;
    logic                     accepted;
    logic [DATA_W-1:0]        byte_count;

    logic [DATA_W-1:0] surf_width  = '0;
    logic [DATA_W-1:0] surf_height = '0;
    logic [DATA_W-1:0] surf_pitch  = '0;
    logic [DATA_W-1:0] surf_bytes  = '0;

    verdict_t expected_verdicts[$];
    int       sender_idle_pct = 27;
    int       items_sent      = 0;
    int       results_checked = 0;
    int       reg_writes      = 0;
    int       error_count     = 0;

    draw_command_validator u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(2_000_000);
        $display("tb: failure");
        $finish;
    end

    function automatic logic on_surface(input logic signed [63:0] x, input logic signed [63:0] y);
        logic signed [63:0] w_s;
        logic signed [63:0] h_s;
        w_s = signed'(64'(surf_width));
        h_s = signed'(64'(surf_height));
        return x >= 0 && y >= 0 && x < w_s && y < h_s;
    endfunction

    function automatic verdict_t judge_command(input draw_cmd_t c);
        verdict_t           v;
        logic [63:0]        row;
        logic [63:0]        total;
        logic signed [63:0] ax, ay, bx, by, cx, cy, area;
        v.st    = ST_VALID;
        v.bytes = '0;
        row     = 64'(surf_pitch) * 64'd4;
        total   = row * 64'(surf_height);
        if (surf_width == 0 || surf_height == 0 || surf_pitch < surf_width || surf_bytes == 0)
            v.st = ST_BAD_SURFACE;
        else if (row > U32_MAX || total > U32_MAX)
            v.st = ST_OVERFLOW;
        else if (total > 64'(surf_bytes))
            v.st = ST_TOO_SMALL;
        else
            v.bytes = total[DATA_W-1:0];

        if (v.st == ST_VALID && c.cmd == CMD_RECT)
        begin
            if (c.rw == 0 || c.rh == 0 || c.rx >= surf_width || c.ry >= surf_height ||
                64'(c.rw) > 64'(surf_width) - 64'(c.rx) ||
                64'(c.rh) > 64'(surf_height) - 64'(c.ry))
                v.st = ST_RECT_OUT;
        end
        else if (v.st == ST_VALID && c.cmd == CMD_TRI)
        begin
            ax = 64'(c.ax);
            ay = 64'(c.ay);
            bx = 64'(c.bx);
            by = 64'(c.by);
            cx = 64'(c.cx);
            cy = 64'(c.cy);
            if (surf_width > TRI_MAX_DIM || surf_height > TRI_MAX_DIM ||
                !on_surface(ax, ay) || !on_surface(bx, by) || !on_surface(cx, cy))
                v.st = ST_TRI_OUT;
            else
            begin
                area = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
                if (area == 0)
                    v.st = ST_DEGENERATE;
            end
        end
        v.acc = (v.st == ST_VALID);
        return v;
    endfunction

    always @(posedge clk)
    begin
        verdict_t exp_v;
        if (rst_n && done)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $error("result with no command outstanding: status %0d", status);
                error_count++;
            end
            else
            begin
                exp_v = expected_verdicts.pop_front();
                results_checked++;
                if (status !== exp_v.st)
                begin
                    $error("status: expected %0d, got %0d", exp_v.st, status);
                    error_count++;
                end
                if (accepted !== exp_v.acc)
                begin
                    $error("accepted: expected %0d, got %0d", exp_v.acc, accepted);
                    error_count++;
                end
                if (byte_count !== exp_v.bytes)
                begin
                    $error("byte_count: expected %0h, got %0h", exp_v.bytes, byte_count);
                    error_count++;
                end
            end
        end
    end

    task automatic send_command(input draw_cmd_t c);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start       <= 1'b1;
        command     <= c.cmd;
        rect_x      <= c.rx;
        rect_y      <= c.ry;
        rect_width  <= c.rw;
        rect_height <= c.rh;
        vertex_a_x  <= c.ax;
        vertex_a_y  <= c.ay;
        vertex_b_x  <= c.bx;
        vertex_b_y  <= c.by;
        vertex_c_x  <= c.cx;
        vertex_c_y  <= c.cy;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_verdicts.push_back(judge_command(c));
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 1) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_SURFACE_WIDTH:  surf_width  = val;
            CFG_SURFACE_HEIGHT: surf_height = val;
            CFG_ROW_PITCH:      surf_pitch  = val;
            CFG_BUFFER_BYTES:   surf_bytes  = val;
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_surface(input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] h,
                               input logic [DATA_W-1:0] p, input logic [DATA_W-1:0] b);
        wait_idle();
        write_reg(CFG_SURFACE_WIDTH, w);
        write_reg(CFG_SURFACE_HEIGHT, h);
        write_reg(CFG_ROW_PITCH, p);
        write_reg(CFG_BUFFER_BYTES, b);
    endtask

    function automatic draw_cmd_t base_command(input logic [1:0] cmd);
        draw_cmd_t c;
        c.cmd = cmd;
        c.rx  = $urandom;
        c.ry  = $urandom;
        c.rw  = $urandom;
        c.rh  = $urandom;
        c.ax  = $urandom;
        c.ay  = $urandom;
        c.bx  = $urandom;
        c.by  = $urandom;
        c.cx  = $urandom;
        c.cy  = $urandom;
        return c;
    endfunction

    task automatic send_rect(input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] y,
                             input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] h);
        draw_cmd_t c;
        c    = base_command(CMD_RECT);
        c.rx = x;
        c.ry = y;
        c.rw = w;
        c.rh = h;
        send_command(c);
    endtask

    task automatic send_tri(input logic signed [DATA_W-1:0] ax, input logic signed [DATA_W-1:0] ay,
                            input logic signed [DATA_W-1:0] bx, input logic signed [DATA_W-1:0] by,
                            input logic signed [DATA_W-1:0] cx, input logic signed [DATA_W-1:0] cy);
        draw_cmd_t c;
        c    = base_command(CMD_TRI);
        c.ax = ax;
        c.ay = ay;
        c.bx = bx;
        c.by = by;
        c.cx = cx;
        c.cy = cy;
        send_command(c);
    endtask

    function automatic draw_cmd_t random_command();
        draw_cmd_t         c;
        int unsigned       pick;
        logic [DATA_W-1:0] mx;
        logic [DATA_W-1:0] my;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            c = base_command(CMD_SURFACE);
        else if (pick < 14)
            c = base_command(CMD_SPARE);
        else if (pick < 55)
            c = base_command(CMD_RECT);
        else
            c = base_command(CMD_TRI);

        if ($urandom_range(0, 9) < 7)
        begin
            c.rx = $urandom_range(0, surf_width - 1);
            c.ry = $urandom_range(0, surf_height - 1);
            c.rw = $urandom_range(1, surf_width - c.rx);
            c.rh = $urandom_range(1, surf_height - c.ry);
            case ($urandom_range(0, 7))
                0: c.rw = surf_width - c.rx + 1;
                1: c.rh = surf_height - c.ry + 1;
                2: c.rx = surf_width;
                3: c.rw = '0;
                4: c.rh = '0;
                default: ;
            endcase

            mx   = (surf_width == 0 || surf_width > TRI_MAX_DIM) ? 4094 : surf_width - 1;
            my   = (surf_height == 0 || surf_height > TRI_MAX_DIM) ? 4094 : surf_height - 1;
            c.ax = $urandom_range(0, mx);
            c.ay = $urandom_range(0, my);
            c.bx = $urandom_range(0, mx);
            c.by = $urandom_range(0, my);
            c.cx = $urandom_range(0, mx);
            c.cy = $urandom_range(0, my);
            case ($urandom_range(0, 9))
                0: begin c.cx = c.ax; c.cy = c.ay; end
                1: begin c.bx = c.ax; c.cx = c.ax; end
                2: c.ay = -$urandom_range(1, 4);
                3: c.cx = surf_width;
                4: c.by = surf_height;
                5: begin c.bx = mx; c.by = my; end
                default: ;
            endcase
        end
        return c;
    endfunction

    task automatic random_surface();
        logic [63:0] w, h, p, b, need;
        int unsigned mode;
        mode = $urandom_range(0, 9);
        w    = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 4095 : 48);
        h    = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 4095 : 48);
        p    = w + $urandom_range(0, 8);
        if (mode == 6)
        begin
            w = $urandom_range(4096, 32'h10_0000);
            p = w + $urandom_range(0, 3);
            h = $urandom_range(1, 32'(U32_MAX / (p * 4)));
        end
        need = p * 4 * h;
        b    = need + $urandom_range(0, 32);
        if (mode == 6 && $urandom_range(0, 1) == 0)
            b = U32_MAX;
        else if (mode == 6)
            b = need;
        if (mode == 7)
            b = need - $urandom_range(1, 32'(need - 1));
        if (mode == 8)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                p = $urandom_range(32'h4000_0000, 32'hFFFF_FFFF);
                w = $urandom_range(1, 32'(p));
                h = $urandom_range(1, 64);
            end
            else
            begin
                p = $urandom_range(32'h1_0000, 32'h3FFF_FFFF);
                w = p;
                h = $urandom_range(32'(U32_MAX / (p * 4)) + 1, 32'hFFFF_FFFF);
            end
            b = $urandom;
        end
        if (mode == 9)
        begin
            w = $urandom;
            h = ($urandom_range(0, 3) == 0) ? 0 : $urandom;
            p = ($urandom_range(0, 1) == 0) ? w - 1 : $urandom;
            b = ($urandom_range(0, 3) == 0) ? 0 : $urandom;
        end
        set_surface(w[DATA_W-1:0], h[DATA_W-1:0], p[DATA_W-1:0], b[DATA_W-1:0]);
    endtask

    task automatic test_reset_defaults();
        send_command(base_command(CMD_SURFACE));
        send_command(base_command(CMD_RECT));
        send_command(base_command(CMD_TRI));
        send_command(base_command(CMD_SPARE));
    endtask

    task automatic test_surface_rules();
        set_surface(0, 16, 16, 1024);
        send_command(base_command(CMD_SURFACE));
        set_surface(16, 0, 16, 1024);
        send_command(base_command(CMD_RECT));
        set_surface(16, 16, 15, 1024);
        send_command(base_command(CMD_TRI));
        set_surface(16, 16, 16, 0);
        send_command(base_command(CMD_SURFACE));
        set_surface('1, '1, '1, '1);
        send_command(base_command(CMD_SPARE));
        set_surface(32'h1_0000, 32'h4000, 32'h1_0000, '1);
        send_command(base_command(CMD_SURFACE));
        set_surface(32'h3FFF_FFFF, 1, 32'h3FFF_FFFF, '1);
        send_command(base_command(CMD_SURFACE));
        send_command(base_command(CMD_TRI));
        set_surface(16, 16, 20, 20 * 4 * 16 - 1);
        send_command(base_command(CMD_SURFACE));
    endtask

    task automatic test_clear_rect();
        set_surface(640, 480, 700, 700 * 4 * 480);
        send_rect(0, 0, 640, 480);
        send_rect(639, 479, 1, 1);
        send_rect(10, 10, 0, 5);
        send_rect(10, 10, 5, 0);
        send_rect(640, 0, 1, 1);
        send_rect(600, 0, 41, 1);
        send_rect(1, 0, '1, 1);
        send_rect('1, '1, '1, '1);
    endtask

    task automatic test_triangle();
        set_surface(4095, 4095, 4095, 4095 * 4 * 4095);
        send_tri(0, 0, 4094, 0, 0, 4094);
        send_tri(0, 0, 100, 100, 4094, 4094);
        send_tri(-1, 0, 10, 0, 0, 10);
        send_tri(0, 4095, 10, 0, 0, 10);
        send_tri(32'sh8000_0000, 0, 32'sh7FFF_FFFF, 0, 0, 10);
        send_command(base_command(CMD_SPARE));
        set_surface(4096, 16, 4096, 4096 * 4 * 16);
        send_tri(0, 0, 1, 0, 0, 1);
    endtask

    task automatic test_random_traffic();
        int idle_plan[3];
        idle_plan = '{27, 58, 0};
        foreach (idle_plan[ph])
        begin
            sender_idle_pct = idle_plan[ph];
            repeat (10)
            begin
                random_surface();
                repeat (51) send_command(random_command());
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        command     = CMD_SURFACE;
        rect_x      = '0;
        rect_y      = '0;
        rect_width  = '0;
        rect_height = '0;
        vertex_a_x  = '0;
        vertex_a_y  = '0;
        vertex_b_x  = '0;
        vertex_b_y  = '0;
        vertex_c_x  = '0;
        vertex_c_y  = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_SURFACE_WIDTH;
        cfg_data    = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_surface_rules();
        test_clear_rect();
        test_triangle();
        test_random_traffic();
        wait_idle();

        $display("%0d commands sent, %0d results compared, %0d register writes",
                 items_sent, results_checked, reg_writes);
        $display("covered surface, clear-rectangle and triangle rules at three sender gap rates");
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
